// ===== rtl/core/cbe_pkg.sv =====
// package for the cltu bch codeblock encoder
// holds shared types, byte constants and the bch register update
// no dependencies
package cbe_pkg;

	localparam logic [7:0] START_0     = 8'hEB;
	localparam logic [7:0] START_1     = 8'h90;
	localparam logic [7:0] FILL_BYTE   = 8'h55;
	localparam logic [7:0] TAIL_MAIN   = 8'hC5;
	localparam logic [7:0] TAIL_LAST   = 8'h79;
	localparam logic [6:0] BCH_TAPS    = 7'h45;
	localparam logic [2:0] INFO_PER_BLOCK = 3'd7;
	localparam logic [2:0] TAIL_LAST_IDX  = 3'd7;

	typedef enum logic [2:0] {
		KIND_START  = 3'd0,
		KIND_INFO   = 3'd1,
		KIND_FILL   = 3'd2,
		KIND_PARITY = 3'd3,
		KIND_TAIL   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_START1,
		PH_INFO,
		PH_PARITY,
		PH_FILL,
		PH_TAIL
	} phase_t;

	// one accepted word as handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       first;
	} cmd_t;

	// shift one byte msb-first into the bch register
	function automatic logic [6:0] bch_shift(input logic [6:0] sr_in, input logic [7:0] b);
		logic [6:0] sr;
		logic       fb;
		sr = sr_in;
		for (int k = 0; k < 8; k++) begin
			fb = sr[6] ^ b[7 - k];
			sr = {sr[5:0], 1'b0};
			if (fb) begin
				sr = sr ^ BCH_TAPS;
			end
		end
		return sr;
	endfunction

endpackage

// ===== rtl/core/cbe_in_if.sv =====
// input channel: one frame byte per word with a last flag
// no dependencies
interface cbe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/cbe_out_if.sv =====
// output channel: one cltu byte per word with its kind and end marks
// no dependencies
interface cbe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] byte_kind;
	logic       run_last;
	logic       cltu_end;

	modport source (output valid, output out_byte, output byte_kind, output run_last,
		output cltu_end, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input run_last,
		input cltu_end, output ready);
endinterface

// ===== rtl/core/cltu_bch_codeblock_encoder.sv =====
// top level of the cltu encoder with (63,56) bch codeblocks
// depends on cbe_pkg, cbe_in_if, cbe_out_if, cbe_front, cbe_queue, cbe_back
//
// Takes one frame byte per word on frame and sends one cltu byte per clock on
// cltu while a word is queued and cltu is ready. The first byte of a unit is
// preceded by two start sequence bytes, the byte that fills a codeblock is
// followed by one parity byte, and the last byte adds up to six fill bytes, one
// parity byte and eight tail bytes. The back-end sequencer emits a single byte
// per clock while cltu is ready; a two-word queue lets the input run ahead
// while those extra bytes go out. run_last marks the final byte caused by each
// input word and cltu_end marks the closing 0x79 of the tail.
module cltu_bch_codeblock_encoder
	import cbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cbe_in_if.sink    frame,
	cbe_out_if.source cltu
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t head;
	logic head_valid;

	cbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	cbe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	cbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cltu       (cltu)
	);

endmodule

// ===== rtl/core/cbe_front.sv =====
// front end: accepts frame bytes and marks the first byte of each unit
// depends on cbe_pkg and cbe_in_if
module cbe_front
	import cbe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	cbe_in_if.sink       frame,
	input  logic         q_full,
	output logic         push,
	output cmd_t         push_cmd
);

	logic unit_open_q;

	assign frame.ready = !q_full;
	assign push        = frame.valid && !q_full;

	always_comb begin
		push_cmd.data  = frame.data_byte;
		push_cmd.last  = frame.last_byte;
		push_cmd.first = !unit_open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_open_q <= 1'b0;
		end else if (push) begin
			unit_open_q <= !frame.last_byte;
		end
	end

endmodule

// ===== rtl/core/cbe_queue.sv =====
// two-entry queue between front and back end
// depends on cbe_pkg
module cbe_queue
	import cbe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic head_valid
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/cbe_back.sv =====
// back end: sequences start, info, fill, parity and tail bytes per word
// depends on cbe_pkg and cbe_out_if
module cbe_back
	import cbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	output logic       pop,
	cbe_out_if.source  cltu
);

	phase_t     ph_q, ph_nxt;
	logic [2:0] pos_q;
	logic [6:0] par_q;
	logic [2:0] tail_cnt_q;

	logic [7:0] byte_q;
	kind_t      kind_q;
	logic       run_last_q;
	logic       end_q;
	logic       out_valid_q;

	logic       fire;
	logic [2:0] pos_inc;
	logic       blk_full;
	logic       is_info;
	logic       tail_done;
	phase_t     info_next;

	logic [7:0] emit_byte;
	kind_t      emit_kind;
	logic       emit_done;
	logic       emit_end;

	assign fire      = head_valid && (!out_valid_q || cltu.ready);
	assign pos_inc   = pos_q + 3'd1;
	assign blk_full  = pos_inc == INFO_PER_BLOCK;
	assign is_info   = (ph_q == PH_HEAD && !head.first) || ph_q == PH_INFO;
	assign tail_done = tail_cnt_q == TAIL_LAST_IDX;
	assign info_next = blk_full ? PH_PARITY : (head.last ? PH_FILL : PH_HEAD);
	assign pop       = fire && emit_done;

	// next phase
	always_comb begin
		case (ph_q)
			PH_HEAD:   ph_nxt = head.first ? PH_START1 : info_next;
			PH_START1: ph_nxt = PH_INFO;
			PH_INFO:   ph_nxt = info_next;
			PH_PARITY: ph_nxt = head.last ? PH_TAIL : PH_HEAD;
			PH_FILL:   ph_nxt = blk_full ? PH_PARITY : PH_FILL;
			PH_TAIL:   ph_nxt = tail_done ? PH_HEAD : PH_TAIL;
			default:   ph_nxt = PH_HEAD;
		endcase
	end

	// byte produced in the current phase
	always_comb begin
		emit_byte = head.data;
		emit_kind = KIND_INFO;
		emit_done = 1'b0;
		emit_end  = 1'b0;
		case (ph_q)
			PH_HEAD: begin
				if (head.first) begin
					emit_byte = START_0;
					emit_kind = KIND_START;
				end else begin
					emit_done = !blk_full && !head.last;
				end
			end
			PH_START1: begin
				emit_byte = START_1;
				emit_kind = KIND_START;
			end
			PH_INFO: begin
				emit_done = !blk_full && !head.last;
			end
			PH_PARITY: begin
				emit_byte = {~par_q, 1'b0};
				emit_kind = KIND_PARITY;
				emit_done = !head.last;
			end
			PH_FILL: begin
				emit_byte = FILL_BYTE;
				emit_kind = KIND_FILL;
			end
			PH_TAIL: begin
				emit_byte = tail_done ? TAIL_LAST : TAIL_MAIN;
				emit_kind = KIND_TAIL;
				emit_done = tail_done;
				emit_end  = tail_done;
			end
			default: begin
				emit_byte = head.data;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_HEAD;
			pos_q       <= 3'd0;
			par_q       <= 7'd0;
			tail_cnt_q  <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				ph_q        <= ph_nxt;
				out_valid_q <= 1'b1;
				if (ph_q == PH_HEAD && head.first) begin
					pos_q <= 3'd0;
					par_q <= 7'd0;
				end else if (is_info) begin
					pos_q <= pos_inc;
					par_q <= bch_shift(par_q, head.data);
				end else if (ph_q == PH_FILL) begin
					pos_q <= pos_inc;
					par_q <= bch_shift(par_q, FILL_BYTE);
				end else if (ph_q == PH_PARITY) begin
					pos_q <= 3'd0;
					par_q <= 7'd0;
				end else if (ph_q == PH_TAIL) begin
					tail_cnt_q <= tail_cnt_q + 3'd1;
					pos_q      <= 3'd0;
					par_q      <= 7'd0;
				end
			end else if (cltu.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q     <= emit_byte;
			kind_q     <= emit_kind;
			run_last_q <= emit_done;
			end_q      <= emit_end;
		end
	end

	assign cltu.valid     = out_valid_q;
	assign cltu.out_byte  = byte_q;
	assign cltu.byte_kind = kind_q;
	assign cltu.run_last  = run_last_q;
	assign cltu.cltu_end  = end_q;

endmodule
